@@ hw/rtl/soda_pkg.sv @@
`timescale 1ns / 1ps

package soda_pkg;

  localparam int OP_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_CIRCLE     = 2'd0,
    OP_BOX        = 2'd1,
    OP_CIRCLE_BOX = 2'd2
  } op_e;

endpackage

@@ hw/rtl/soda_sqrt_cell.sv @@
`timescale 1ns / 1ps

module soda_sqrt_cell #(
  parameter int ROOT_W = 17,
  parameter int RAD_W  = 34,
  parameter int SIDE_W = 19
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [ROOT_W+1:0]        rem_i,
  input  logic [ROOT_W-1:0]        root_i,
  input  logic [RAD_W-1:0]         rad_i,
  input  logic signed [SIDE_W-1:0] side_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [ROOT_W+1:0]        rem_o,
  output logic [ROOT_W-1:0]        root_o,
  output logic [RAD_W-1:0]         rad_o,
  output logic signed [SIDE_W-1:0] side_o
);

  localparam int REM_W = ROOT_W + 2;

  logic                     valid_q;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [ROOT_W-1:0]        root_q, root_d;
  logic [RAD_W-1:0]         rad_q, rad_d;
  logic signed [SIDE_W-1:0] side_q;
  logic [REM_W+1:0]         rem_n;
  logic [REM_W+1:0]         trial;
  logic                     load;

  assign ready_o = !valid_q || ready_i;
  assign load    = ready_o;

  // one root bit per cell
  always_comb begin
    rem_n = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial = (REM_W + 2)'({root_i, 2'b01});
    if (rem_n >= trial) begin
      rem_d  = REM_W'(rem_n - trial);
      root_d = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = REM_W'(rem_n);
      root_d = {root_i[ROOT_W-2:0], 1'b0};
    end
    rad_d = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

@@ hw/rtl/soda_front.sv @@
`timescale 1ns / 1ps

module soda_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [soda_pkg::OP_BITS-1:0]  operation_i,
  input  logic signed [COORD_BITS-1:0]  a_x_i,
  input  logic signed [COORD_BITS-1:0]  a_y_i,
  input  logic [COORD_BITS-2:0]         a_extent_x_i,
  input  logic [COORD_BITS-2:0]         a_extent_y_i,
  input  logic signed [COORD_BITS-1:0]  b_x_i,
  input  logic signed [COORD_BITS-1:0]  b_y_i,
  input  logic [COORD_BITS-2:0]         b_extent_x_i,
  input  logic [COORD_BITS-2:0]         b_extent_y_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [2*COORD_BITS:0]         sum_o,
  output logic signed [COORD_BITS+2:0]  base_o
);

  import soda_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 3;
  localparam int SW = 2 * CW;

  logic signed [DW-1:0] ax, ay, bx, by, aex, aey, bex, bey;
  logic signed [DW-1:0] dx, dy, adx, ady;
  logic signed [DW-1:0] hi_x, lo_x, hi_y, lo_y, cbx, cby;
  logic signed [DW-1:0] ox1, ox2, oy1, oy2, ox, oy;
  logic [CW-1:0]        mx_d, my_d;
  logic signed [DW-1:0] base_d;

  logic                 v1_q, v2_q, v3_q;
  logic                 r1, r2, r3;
  logic [CW-1:0]        mx_q, my_q;
  logic signed [DW-1:0] base1_q, base2_q, base3_q;
  logic [SW-1:0]        sqx_q, sqy_q;
  logic [SW:0]          sum_q;

  assign ax  = DW'(a_x_i);
  assign ay  = DW'(a_y_i);
  assign bx  = DW'(b_x_i);
  assign by  = DW'(b_y_i);
  assign aex = signed'(DW'(a_extent_x_i));
  assign aey = signed'(DW'(a_extent_y_i));
  assign bex = signed'(DW'(b_extent_x_i));
  assign bey = signed'(DW'(b_extent_y_i));

  always_comb begin
    dx   = ax - bx;
    dy   = ay - by;
    adx  = dx[DW-1] ? -dx : dx;
    ady  = dy[DW-1] ? -dy : dy;
    hi_x = bx + bex;
    lo_x = bx - bex;
    hi_y = by + bey;
    lo_y = by - bey;
    // per-axis distance from the circle centre to the nearest box point
    if (ax > hi_x) begin
      cbx = ax - hi_x;
    end else if (ax < lo_x) begin
      cbx = lo_x - ax;
    end else begin
      cbx = '0;
    end
    if (ay > hi_y) begin
      cby = ay - hi_y;
    end else if (ay < lo_y) begin
      cby = lo_y - ay;
    end else begin
      cby = '0;
    end
    ox1 = (ax + aex) - lo_x;
    ox2 = hi_x - (ax - aex);
    oy1 = (ay + aey) - lo_y;
    oy2 = hi_y - (ay - aey);
    ox  = (ox1 < ox2) ? ox1 : ox2;
    oy  = (oy1 < oy2) ? oy1 : oy2;
    unique case (operation_i)
      OP_CIRCLE: begin
        mx_d   = adx[CW-1:0];
        my_d   = ady[CW-1:0];
        base_d = aex + bex;
      end
      OP_BOX: begin
        mx_d   = '0;
        my_d   = '0;
        base_d = (ox < oy) ? ox : oy;
      end
      OP_CIRCLE_BOX: begin
        mx_d   = cbx[CW-1:0];
        my_d   = cby[CW-1:0];
        base_d = aex;
      end
      default: begin
        mx_d   = '0;
        my_d   = '0;
        base_d = '0;
      end
    endcase
  end

  assign r3 = !v3_q || ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_stall_o = !r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= in_valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      mx_q    <= mx_d;
      my_q    <= my_d;
      base1_q <= base_d;
    end
    if (r2) begin
      sqx_q   <= SW'(mx_q * mx_q);
      sqy_q   <= SW'(my_q * my_q);
      base2_q <= base1_q;
    end
    if (r3) begin
      sum_q   <= (SW + 1)'(sqx_q) + (SW + 1)'(sqy_q);
      base3_q <= base2_q;
    end
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign base_o  = base3_q;

endmodule

@@ hw/rtl/shape_overlap_depth_top.sv @@
`timescale 1ns / 1ps
// stages from input transfer to result: three front stages,
// one square root cell per root bit, one output register
// throughput: one shape pair per cycle, each stage advances when its successor frees
// reset: asynchronous, clears all stage valid bits; the pipeline comes up empty
// a stalled output holds its result while empty stages upstream still take transfers

module shape_overlap_depth_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [soda_pkg::OP_BITS-1:0]  operation_i,
  input  logic signed [COORD_BITS-1:0]  a_x_i,
  input  logic signed [COORD_BITS-1:0]  a_y_i,
  input  logic [COORD_BITS-2:0]         a_extent_x_i,
  input  logic [COORD_BITS-2:0]         a_extent_y_i,
  input  logic signed [COORD_BITS-1:0]  b_x_i,
  input  logic signed [COORD_BITS-1:0]  b_y_i,
  input  logic [COORD_BITS-2:0]         b_extent_x_i,
  input  logic [COORD_BITS-2:0]         b_extent_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS+2:0]  depth_o,
  output logic                          overlapping_o
);

  import soda_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int DW     = CW + 3;
  localparam int ROOT_W = CW + 1;
  localparam int RAD_W  = 2 * CW + 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NCELL  = ROOT_W;

  logic                 valid_c [0:NCELL];
  logic                 ready_c [0:NCELL];
  logic [REM_W-1:0]     rem_c   [0:NCELL];
  logic [ROOT_W-1:0]    root_c  [0:NCELL];
  logic [RAD_W-1:0]     rad_c   [0:NCELL];
  logic signed [DW-1:0] side_c  [0:NCELL];
  logic [2*CW:0]        sum;

  logic                 out_valid_q;
  logic signed [DW-1:0] depth_q, depth_d;
  logic                 ovl_q;
  logic                 out_load;

  soda_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .a_x_i       (a_x_i),
    .a_y_i       (a_y_i),
    .a_extent_x_i(a_extent_x_i),
    .a_extent_y_i(a_extent_y_i),
    .b_x_i       (b_x_i),
    .b_y_i       (b_y_i),
    .b_extent_x_i(b_extent_x_i),
    .b_extent_y_i(b_extent_y_i),
    .valid_o     (valid_c[0]),
    .ready_i     (ready_c[0]),
    .sum_o       (sum),
    .base_o      (side_c[0])
  );

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign rad_c[0]  = RAD_W'(sum);

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    soda_sqrt_cell #(
      .ROOT_W(ROOT_W),
      .RAD_W (RAD_W),
      .SIDE_W(DW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[k]),
      .ready_o(ready_c[k]),
      .rem_i  (rem_c[k]),
      .root_i (root_c[k]),
      .rad_i  (rad_c[k]),
      .side_i (side_c[k]),
      .valid_o(valid_c[k+1]),
      .ready_i(ready_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .root_o (root_c[k+1]),
      .rad_o  (rad_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  assign out_load       = !out_valid_q || !out_stall_i;
  assign ready_c[NCELL] = out_load;
  assign depth_d        = side_c[NCELL] - signed'(DW'(root_c[NCELL]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= valid_c[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      depth_q <= depth_d;
      ovl_q   <= (depth_d > 0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign depth_o       = depth_q;
  assign overlapping_o = ovl_q;

endmodule

@@ verif/shape_overlap_depth_top_tb.sv @@
`timescale 1ns / 1ps

module shape_overlap_depth_top_tb;
  import soda_pkg::*;

  localparam int CB = 16;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [OP_BITS-1:0] operation;
    logic signed [CB-1:0] a_x;
    logic signed [CB-1:0] a_y;
    logic [CB-2:0] a_extent_x;
    logic [CB-2:0] a_extent_y;
    logic signed [CB-1:0] b_x;
    logic signed [CB-1:0] b_y;
    logic [CB-2:0] b_extent_x;
    logic [CB-2:0] b_extent_y;
  } shape_pair_t;

  typedef struct {
    logic signed [CB+2:0] depth;
    logic overlapping;
  } overlap_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [OP_BITS-1:0] operation_i;
  logic signed [CB-1:0] a_x_i;
  logic signed [CB-1:0] a_y_i;
  logic [CB-2:0] a_extent_x_i;
  logic [CB-2:0] a_extent_y_i;
  logic signed [CB-1:0] b_x_i;
  logic signed [CB-1:0] b_y_i;
  logic [CB-2:0] b_extent_x_i;
  logic [CB-2:0] b_extent_y_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [CB+2:0] depth_o;
  logic overlapping_o;

  overlap_t expected_q[$];
  int errors = 0;
  int tx_max_gap = 3;
  int rx_max_stall = 3;
  int hold_cycles = 0;
  int idle_cycles = 0;

  shape_overlap_depth_top #(.COORD_BITS(CB)) u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    rem = 0;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint centre_distance(longint dx, longint dy);
    longint unsigned sq;
    sq = longint'(dx * dx + dy * dy);
    return $signed(floor_root(sq));
  endfunction

  function automatic longint min_of(longint p, longint q);
    return (p < q) ? p : q;
  endfunction

  function automatic overlap_t predict_overlap(shape_pair_t p);
    longint ax, ay, aex, aey, bx, by, bex, bey;
    longint d, ox, oy, px, py;
    overlap_t r;
    ax = p.a_x;
    ay = p.a_y;
    aex = p.a_extent_x;
    aey = p.a_extent_y;
    bx = p.b_x;
    by = p.b_y;
    bex = p.b_extent_x;
    bey = p.b_extent_y;
    case (p.operation)
      OP_CIRCLE: begin
        d = (aex + bex) - centre_distance(ax - bx, ay - by);
      end
      OP_BOX: begin
        ox = min_of((ax + aex) - (bx - bex), (bx + bex) - (ax - aex));
        oy = min_of((ay + aey) - (by - bey), (by + bey) - (ay - aey));
        d = min_of(ox, oy);
      end
      OP_CIRCLE_BOX: begin
        px = ax;
        if (px > bx + bex) px = bx + bex;
        if (px < bx - bex) px = bx - bex;
        py = ay;
        if (py > by + bey) py = by + bey;
        if (py < by - bey) py = by - bey;
        d = aex - centre_distance(ax - px, ay - py);
      end
      default: begin
        d = 0;
      end
    endcase
    r.depth = d[CB+2:0];
    r.overlapping = (d > 0);
    return r;
  endfunction

  function automatic shape_pair_t make_pair(logic [OP_BITS-1:0] op, int ax, int ay, int aex,
                                            int aey, int bx, int by, int bex, int bey);
    shape_pair_t p;
    p.operation = op;
    p.a_x = CB'(ax);
    p.a_y = CB'(ay);
    p.a_extent_x = (CB-1)'(aex);
    p.a_extent_y = (CB-1)'(aey);
    p.b_x = CB'(bx);
    p.b_y = CB'(by);
    p.b_extent_x = (CB-1)'(bex);
    p.b_extent_y = (CB-1)'(bey);
    return p;
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    logic signed [CB-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {1'b1, {(CB-1){1'b0}}};
      1: v = {1'b0, {(CB-1){1'b1}}};
      2: begin
        v = CB'(int'($urandom_range(0, 511)) - 256);
      end
      default: v = CB'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [CB-2:0] rand_extent();
    logic [CB-2:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = (CB-1)'($urandom_range(0, 300));
      default: v = (CB-1)'($urandom);
    endcase
    return v;
  endfunction

  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    logic signed [CB-1:0] off;
    if ($urandom_range(0, 15) == 0) p.operation = OP_UNUSED;
    else p.operation = OP_BITS'($urandom_range(0, 2));
    p.a_x = rand_coord();
    p.a_y = rand_coord();
    p.a_extent_x = rand_extent();
    p.a_extent_y = rand_extent();
    p.b_extent_x = rand_extent();
    p.b_extent_y = rand_extent();
    if ($urandom_range(0, 1) == 0) begin
      p.b_x = rand_coord();
      p.b_y = rand_coord();
    end else begin
      // second shape near the first, so that touching and shallow overlaps turn up
      off = CB'($urandom_range(0, 1023));
      p.b_x = CB'(p.a_x + off - 512);
      off = CB'($urandom_range(0, 1023));
      p.b_y = CB'(p.a_y + off - 512);
    end
    return p;
  endfunction

  task automatic send_pair(input shape_pair_t p);
    int gap;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operation_i <= p.operation;
    a_x_i <= p.a_x;
    a_y_i <= p.a_y;
    a_extent_x_i <= p.a_extent_x;
    a_extent_y_i <= p.a_extent_y;
    b_x_i <= p.b_x;
    b_y_i <= p.b_y;
    b_extent_x_i <= p.b_extent_x;
    b_extent_y_i <= p.b_extent_y;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_overlap(p));
  endtask

  task automatic test_circle_pairs();
    send_pair(make_pair(OP_CIRCLE, 0, 0, 32767, 32767, 0, 0, 32767, 32767));
    send_pair(make_pair(OP_CIRCLE, -32768, -32768, 0, 0, 32767, 32767, 0, 0));
    send_pair(make_pair(OP_CIRCLE, 0, 0, 48, 0, 80, 0, 32, 0));
    send_pair(make_pair(OP_CIRCLE, 0, 0, 48, 0, 80, 0, 33, 0));
    send_pair(make_pair(OP_CIRCLE, 32767, -32768, 0, 0, -32768, 32767, 32767, 32767));
  endtask

  task automatic test_box_pairs();
    send_pair(make_pair(OP_BOX, 0, 0, 32767, 32767, 0, 0, 32767, 32767));
    send_pair(make_pair(OP_BOX, -32768, -32768, 0, 0, 32767, 32767, 0, 0));
    send_pair(make_pair(OP_BOX, 0, 0, 16, 16, 32, 0, 16, 16));
    send_pair(make_pair(OP_BOX, 100, -40, 500, 30, 90, 0, 400, 20));
    send_pair(make_pair(OP_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_circle_box_pairs();
    // centre inside the box
    send_pair(make_pair(OP_CIRCLE_BOX, 5, 5, 100, 0, 0, 0, 50, 50));
    send_pair(make_pair(OP_CIRCLE_BOX, -32768, -32768, 0, 0, 32767, 32767, 0, 0));
    send_pair(make_pair(OP_CIRCLE_BOX, 32767, 32767, 32767, 32767,
                        -32768, -32768, 32767, 32767));
    send_pair(make_pair(OP_CIRCLE_BOX, 100, 100, 50, 0, 0, 0, 50, 50));
    send_pair(make_pair(OP_CIRCLE_BOX, -32768, 0, 32767, 0, 32767, 0, 32767, 0));
  endtask

  task automatic test_unused_selector();
    send_pair(make_pair(OP_UNUSED, 0, 0, 32767, 32767, 0, 0, 32767, 32767));
    send_pair(make_pair(OP_UNUSED, -32768, 32767, 0, 32767, 32767, -32768, 32767, 0));
    send_pair(make_pair(OP_UNUSED, 1, -1, 5, 5, -1, 1, 5, 5));
  endtask

  task automatic test_ignored_extents();
    send_pair(make_pair(OP_CIRCLE, 10, 20, 300, 0, -200, 100, 150, 0));
    send_pair(make_pair(OP_CIRCLE, 10, 20, 300, 32767, -200, 100, 150, 32767));
    send_pair(make_pair(OP_CIRCLE_BOX, 400, 300, 200, 0, 0, 0, 160, 120));
    send_pair(make_pair(OP_CIRCLE_BOX, 400, 300, 200, 32767, 0, 0, 160, 120));
  endtask

  task automatic test_output_backpressure();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    tx_max_gap = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (60) send_pair(random_pair());
  endtask

  task automatic test_random_pairs(int count, int max_gap, int max_stall);
    tx_max_gap = max_gap;
    rx_max_stall = max_stall;
    repeat (count) send_pair(random_pair());
  endtask

  // result sink: draws a stall length for every result
  initial begin
    int n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    overlap_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: depth %0d", depth_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (depth_o !== exp_r.depth) begin
          $error("depth: expected %0d, got %0d", exp_r.depth, depth_o);
          errors++;
        end
        if (overlapping_o !== exp_r.overlapping) begin
          $error("overlapping: expected %0d, got %0d", exp_r.overlapping, overlapping_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    operation_i <= '0;
    a_x_i <= '0;
    a_y_i <= '0;
    a_extent_x_i <= '0;
    a_extent_y_i <= '0;
    b_x_i <= '0;
    b_y_i <= '0;
    b_extent_x_i <= '0;
    b_extent_y_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_circle_pairs();
    test_box_pairs();
    test_circle_box_pairs();
    test_unused_selector();
    test_ignored_extents();
    test_output_backpressure();
    test_random_pairs(400, 0, 0);
    test_random_pairs(400, 18, 18);
    test_random_pairs(400, 3, 18);
    test_random_pairs(400, 18, 3);

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ shape_overlap_depth_top.f @@
hw/rtl/soda_pkg.sv
hw/rtl/soda_sqrt_cell.sv
hw/rtl/soda_front.sv
hw/rtl/shape_overlap_depth_top.sv
verif/shape_overlap_depth_top_tb.sv
